FILE: sv/antialiased_line_generator_defines.svh
// Assertion macros for the antialiased line generator.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef ANTIALIASED_LINE_GENERATOR_DEFINES_SVH
`define ANTIALIASED_LINE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALG_ASSERT_IMPLY(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALG_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/alg_pkg.sv
// Shared constants and types of the antialiased line generator.
// Used by the channel interfaces, the controller, the datapath and the divider.
package alg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 16;
  localparam int CHAN_BITS    = 8;
  localparam int Q_BITS       = 8;
  localparam int W_BITS       = Q_BITS + 1;
  localparam int PIX_BITS     = COORD_BITS + 1;
  localparam int STEP_BITS    = COORD_BITS + 1;
  localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
  localparam int GRAD_BITS    = FRAC_BITS + 2;
  localparam int QUO_BITS     = FRAC_BITS + 1;
  localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);
  localparam logic [W_BITS-1:0] WEIGHT_FULL = W_BITS'(1 << Q_BITS);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic orient;
    logic order;
    logic div_start;
    logic clear_grad;
    logic finish;
    logic emit_first;
    logic emit_second;
  } alg_cmd_t;

  typedef struct packed {
    logic    in_valid;
    opcode_t in_op;
    logic    line_active;
    logic    out_free;
    logic    div_done;
  } alg_status_t;

endpackage

FILE: sv/alg_if.sv
// Channel interfaces of the antialiased line generator: request items in, pixel items out.
// Depends on alg_pkg for the field widths.
interface alg_in_if;
  import alg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [CHAN_BITS-1:0]  line_red;
  logic [CHAN_BITS-1:0]  line_green;
  logic [CHAN_BITS-1:0]  line_blue;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, line_red, line_green, line_blue,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, line_red, line_green, line_blue,
    output ready
  );
endinterface

interface alg_out_if;
  import alg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_BITS-1:0]  pixel_x;
  logic [PIX_BITS-1:0]  pixel_y;
  logic [CHAN_BITS-1:0] pixel_red;
  logic [CHAN_BITS-1:0] pixel_green;
  logic [CHAN_BITS-1:0] pixel_blue;
  logic                 last_of_pair;
  logic                 line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, last_of_pair,
           line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, last_of_pair,
           line_done,
    output ready
  );
endinterface

FILE: sv/alg_div.sv
// Restoring divider for the line gradient: one quotient bit per cycle.
// Depends on alg_pkg for widths.
module alg_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [alg_pkg::COORD_BITS-1:0]   numer,
  input  logic [alg_pkg::COORD_BITS-1:0]   denom,
  output logic                             done,
  output logic [alg_pkg::QUO_BITS-1:0]     quotient
);
  import alg_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] count;
  logic [COORD_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]     quo;
  logic [COORD_BITS:0]     trial;
  logic [COORD_BITS:0]     diff;
  logic                    fits;

  assign trial    = {rem, quo[DIV_BITS-1]};
  assign fits     = trial >= {1'b0, denom};
  assign diff     = trial - {1'b0, denom};
  assign quotient = quo[QUO_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= {numer, {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

endmodule

FILE: sv/alg_datapath.sv
// Datapath of the antialiased line generator: line setup, stepping state and pixel register.
// Depends on alg_pkg, the channel interfaces and alg_div.
module alg_datapath (
  input  logic                 clk,
  input  logic                 rst,
  alg_in_if.sink               req,
  alg_out_if.source            pix,
  input  alg_pkg::alg_cmd_t    cmd,
  output alg_pkg::alg_status_t status
);
  import alg_pkg::*;

  logic [COORD_BITS-1:0]  sx, sy, ex, ey;
  logic [3*CHAN_BITS-1:0] colour_store;
  logic                   major_is_y;
  logic [COORD_BITS-1:0]  major_position;
  logic [ACC_BITS-1:0]    minor_acc;
  logic [GRAD_BITS-1:0]   gradient;
  logic [STEP_BITS-1:0]   steps_left;
  logic                   div_neg;
  logic [COORD_BITS-1:0]  div_num;
  logic [COORD_BITS-1:0]  div_den;

  logic                   out_valid;
  logic [PIX_BITS-1:0]    out_x, out_y;
  logic [CHAN_BITS-1:0]   out_red, out_green, out_blue;
  logic                   out_last, out_done;

  logic                   div_done;
  logic [QUO_BITS-1:0]    quotient;

  logic [COORD_BITS-1:0]  adx, ady;
  logic [COORD_BITS-1:0]  maj0_raw, maj1_raw, min0_raw, min1_raw;
  logic                   swap;
  logic [COORD_BITS-1:0]  maj0, maj1, min0, min1;
  logic [GRAD_BITS-1:0]   grad_mag;

  logic [COORD_BITS-1:0]  minor;
  logic [Q_BITS-1:0]      q8;
  logic [PIX_BITS-1:0]    minor_pix, major_pix;
  logic [W_BITS-1:0]      weight;
  logic                   emitting;

  function automatic logic [CHAN_BITS-1:0] scale_chan(logic [CHAN_BITS-1:0] c,
                                                      logic [W_BITS-1:0] w);
    logic [CHAN_BITS+W_BITS-1:0] p;
    p = (CHAN_BITS + W_BITS)'(c) * (CHAN_BITS + W_BITS)'(w);
    return p[CHAN_BITS+Q_BITS-1:Q_BITS];
  endfunction

  alg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .numer    (div_num),
    .denom    (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  assign req.ready          = cmd.in_ready;
  assign status.in_valid    = req.valid;
  assign status.in_op       = opcode_t'(req.opcode);
  assign status.line_active = steps_left != '0;
  assign status.out_free    = !out_valid || pix.ready;
  assign status.div_done    = div_done;

  assign adx = (ex >= sx) ? ex - sx : sx - ex;
  assign ady = (ey >= sy) ? ey - sy : sy - ey;

  always_comb begin
    maj0_raw = major_is_y ? sy : sx;
    maj1_raw = major_is_y ? ey : ex;
    min0_raw = major_is_y ? sx : sy;
    min1_raw = major_is_y ? ex : ey;
    swap     = maj0_raw > maj1_raw;
    maj0     = swap ? maj1_raw : maj0_raw;
    maj1     = swap ? maj0_raw : maj1_raw;
    min0     = swap ? min1_raw : min0_raw;
    min1     = swap ? min0_raw : min1_raw;
  end

  assign grad_mag = {1'b0, quotient};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx           <= req.start_x;
      sy           <= req.start_y;
      ex           <= req.end_x;
      ey           <= req.end_y;
      colour_store <= {req.line_red, req.line_green, req.line_blue};
    end
    if (cmd.orient) begin
      major_is_y <= adx < ady;
    end
    if (cmd.order) begin
      major_position <= maj0;
      minor_acc      <= {1'b0, min0, {FRAC_BITS{1'b0}}};
      div_neg        <= min1 < min0;
      div_num        <= (min1 < min0) ? min0 - min1 : min1 - min0;
      div_den        <= maj1 - maj0;
    end
    if (cmd.clear_grad) begin
      gradient <= '0;
    end
    if (cmd.finish) begin
      gradient <= div_neg ? -grad_mag : grad_mag;
    end
    if (cmd.emit_second) begin
      minor_acc      <= minor_acc + {{(ACC_BITS-GRAD_BITS){gradient[GRAD_BITS-1]}}, gradient};
      major_position <= major_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (cmd.order) begin
      steps_left <= {1'b0, maj1 - maj0};
    end else if (cmd.emit_second) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  assign minor     = minor_acc[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  assign q8        = minor_acc[FRAC_BITS-1 -: Q_BITS];
  assign minor_pix = {1'b0, minor} + {{(PIX_BITS-1){1'b0}}, cmd.emit_second};
  assign major_pix = {1'b0, major_position};
  assign weight    = cmd.emit_second ? {1'b0, q8} : WEIGHT_FULL - {1'b0, q8};
  assign emitting  = cmd.emit_first || cmd.emit_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emitting) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      out_x     <= major_is_y ? minor_pix : major_pix;
      out_y     <= major_is_y ? major_pix : minor_pix;
      out_red   <= scale_chan(colour_store[3*CHAN_BITS-1:2*CHAN_BITS], weight);
      out_green <= scale_chan(colour_store[2*CHAN_BITS-1:CHAN_BITS], weight);
      out_blue  <= scale_chan(colour_store[CHAN_BITS-1:0], weight);
      out_last  <= cmd.emit_second;
      out_done  <= steps_left == STEP_BITS'(1);
    end
  end

  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.pixel_red    = out_red;
  assign pix.pixel_green  = out_green;
  assign pix.pixel_blue   = out_blue;
  assign pix.last_of_pair = out_last;
  assign pix.line_done    = out_done;

endmodule

FILE: sv/alg_ctrl.sv
// Controller of the antialiased line generator: sequences line setup, division and pixel pairs.
// Depends on alg_pkg and the assertion macros header.
`include "antialiased_line_generator_defines.svh"

module alg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  alg_pkg::alg_status_t status,
  output alg_pkg::alg_cmd_t    cmd
);
  import alg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ORIENT = 6'b000010,
    ST_ORDER  = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = status.out_free;
        if (status.out_free && status.in_valid) begin
          if (status.in_op == OP_LOAD) begin
            cmd.capture = 1'b1;
            state_next  = ST_ORIENT;
          end else if (status.in_op == OP_STEP && status.line_active) begin
            cmd.emit_first = 1'b1;
            state_next     = ST_EMIT;
          end
        end
      end
      ST_ORIENT: begin
        cmd.orient = 1'b1;
        state_next = ST_ORDER;
      end
      ST_ORDER: begin
        cmd.order  = 1'b1;
        state_next = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (status.line_active) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          cmd.clear_grad = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_second = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ALG_ASSERT_NEXT(a_first_then_pair, clk, rst, cmd.emit_first, state == ST_EMIT && status.line_active, "first pixel not followed by its pair")
  `ALG_ASSERT_IMPLY(a_emit_needs_line, clk, rst, state == ST_EMIT, status.line_active, "pair pending with no active line")
  `ALG_ASSERT_NEXT(a_divide_holds, clk, rst, state == ST_DIVIDE && !status.div_done, state == ST_DIVIDE, "left divide before quotient ready")
  `ALG_ASSERT_IMPLY(a_done_in_divide, clk, rst, status.div_done, state == ST_DIVIDE, "quotient ready outside divide")

endmodule

FILE: sv/antialiased_line_generator.sv
// Top level of the antialiased line generator: controller, datapath and gradient divider.
// Depends on alg_pkg, alg_if, alg_ctrl and alg_datapath.
//
//   channel  role  carries
//   req      sink  opcode, two endpoints and a colour (load) or a step request
//   pix      src   one pixel: coordinate, scaled colour, last_of_pair, line_done
//
// A step with an active line emits the first pixel in ST_IDLE, the second in ST_EMIT once output is free.
// A load steps through ST_ORIENT, ST_ORDER and ST_LAUNCH, then waits in ST_DIVIDE for the
// bit-serial gradient divider; a zero-length line skips the divider and returns to ST_IDLE.
// A step with no active line is accepted and gives no pixel.
// Reset is synchronous and leaves no line active and the pixel register empty.
// The pixel register holds its item while pix.ready is low; req.ready stays low until it drains.
module antialiased_line_generator (
  input  logic      clk,
  input  logic      rst,
  alg_in_if.sink    req,
  alg_out_if.source pix
);
  import alg_pkg::*;

  alg_cmd_t    cmd;
  alg_status_t status;

  alg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  alg_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .pix    (pix),
    .cmd    (cmd),
    .status (status)
  );

endmodule
